/* rtl/gsa_pkg.sv */
`default_nettype none

package gsa_pkg;

    localparam int CAPACITY = 1024;
    localparam int GEN_BITS = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic ACT_CREATE  = 1'b0;
    localparam logic ACT_DESTROY = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic                action;
        logic [IDX_W-1:0]    handle_index;
        logic [GEN_BITS-1:0] handle_generation;
    } req_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    entity_index;
        logic [GEN_BITS-1:0] entity_generation;
        logic [CNT_W-1:0]    live_count;
    } rsp_word_t;

    typedef struct packed {
        logic                active;
        logic [GEN_BITS-1:0] gen;
    } slot_t;

    typedef struct packed {
        logic start;
        logic fetch;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic need_fetch;
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FETCH  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* rtl/generational_slot_allocator.sv */
// channel  direction  handshake             word
// req      in         req_valid/req_ready   action, handle_index, handle_generation
// rsp      out        rsp_valid/rsp_ready   status, entity_index, entity_generation, live_count
//
// create steps: free stack read, slot read, commit
// full create and destroy steps: memory reads, commit
// a new word is taken the cycle after commit; the slot table needs no clearing
// pass, slots at or above the high-water mark read as inactive with generation zero
// commit waits while a previous rsp word is not taken

`default_nettype none

module generational_slot_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gsa_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gsa_pkg::rsp_word_t rsp
);
    import gsa_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    gsa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    gsa_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!rsp_valid || rsp_ready))
        else $error("rsp word overwritten before taken");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req taken while previous word in work");

    a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> rsp_valid)
        else $error("commit without rsp word");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_DONE || rsp.status == ST_FULL
                       || rsp.status == ST_STALE))
        else $error("bad status code");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.live_count <= CNT_W'(CAPACITY)))
        else $error("live count above capacity");

endmodule

`default_nettype wire

/* rtl/gsa_controller.sv */
`default_nettype none

module gsa_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  gsa_pkg::stat_t stat,
    output gsa_pkg::ctl_t  ctl
);
    import gsa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        ctl.start  = (state_reg == S_IDLE) && req_valid;
        ctl.fetch  = (state_reg == S_FETCH);
        ctl.commit = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = stat.need_fetch ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (ctl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

/* rtl/gsa_datapath.sv */
`default_nettype none

module gsa_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gsa_pkg::ctl_t      ctl,
    output gsa_pkg::stat_t     stat,
    input  gsa_pkg::req_word_t req,
    output gsa_pkg::rsp_word_t rsp
);
    import gsa_pkg::*;

    slot_t            slot_mem   [CAPACITY];
    logic [IDX_W-1:0] dense_list [CAPACITY];
    logic [IDX_W-1:0] dense_pos  [CAPACITY];
    logic [IDX_W-1:0] free_stack [CAPACITY];

    slot_t            slot_rd_reg;
    logic [IDX_W-1:0] dlist_rd_reg;
    logic [IDX_W-1:0] dpos_rd_reg;
    logic [IDX_W-1:0] fs_rd_reg;

    logic [CNT_W-1:0] free_depth_reg;
    logic [CNT_W-1:0] free_depth_next;
    logic [CNT_W-1:0] high_water_reg;
    logic [CNT_W-1:0] high_water_next;
    logic [CNT_W-1:0] alive_reg;
    logic [CNT_W-1:0] alive_next;

    logic                act_reg;
    logic [IDX_W-1:0]    hidx_reg;
    logic [GEN_BITS-1:0] hgen_reg;
    logic                use_free_reg;
    logic                full_reg;
    logic                unused_reg;
    logic [IDX_W-1:0]    slot_idx_reg;
    logic                fresh_reg;
    rsp_word_t           rsp_reg;
    rsp_word_t           rsp_next;

    logic             free_empty;
    logic             hw_full;
    logic             idx_unused;
    logic [CNT_W-1:0] fd_top;
    logic [CNT_W-1:0] last_pos;
    logic [IDX_W-1:0] new_idx;

    logic             slot_re;
    logic [IDX_W-1:0] slot_raddr;
    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr;
    slot_t            slot_wdata;
    logic             dlist_we;
    logic [IDX_W-1:0] dlist_waddr;
    logic [IDX_W-1:0] dlist_wdata;
    logic             dpos_we;
    logic [IDX_W-1:0] dpos_waddr;
    logic [IDX_W-1:0] dpos_wdata;
    logic             fs_we;

    logic                create_ok;
    logic                destroy_ok;
    logic [GEN_BITS-1:0] create_gen;
    logic [GEN_BITS-1:0] gen_inc;

    assign free_empty = (free_depth_reg == '0);
    assign hw_full    = (high_water_reg == CNT_W'(CAPACITY));
    assign idx_unused = (CNT_W'(req.handle_index) >= high_water_reg);
    assign fd_top     = free_depth_reg - 1'b1;
    assign last_pos   = alive_reg - 1'b1;
    assign new_idx    = use_free_reg ? fs_rd_reg : high_water_reg[IDX_W-1:0];

    assign stat.need_fetch = (req.action == ACT_CREATE) && !(free_empty && hw_full);

    assign slot_re    = ctl.start || ctl.fetch;
    assign slot_raddr = ctl.start ? req.handle_index : new_idx;

    // slots at or above the high-water mark read as inactive, generation zero
    assign create_gen = fresh_reg ? '0 : slot_rd_reg.gen;
    assign gen_inc    = slot_rd_reg.gen + 1'b1;
    assign create_ok  = (act_reg == ACT_CREATE) && !full_reg;
    assign destroy_ok = (act_reg == ACT_DESTROY) && !unused_reg && slot_rd_reg.active
                        && (slot_rd_reg.gen == hgen_reg);

    always_comb
    begin
        slot_we         = 1'b0;
        slot_waddr      = slot_idx_reg;
        slot_wdata      = '{active: 1'b1, gen: create_gen};
        dlist_we        = 1'b0;
        dlist_waddr     = alive_reg[IDX_W-1:0];
        dlist_wdata     = slot_idx_reg;
        dpos_we         = 1'b0;
        dpos_waddr      = slot_idx_reg;
        dpos_wdata      = alive_reg[IDX_W-1:0];
        fs_we           = 1'b0;
        free_depth_next = free_depth_reg;
        high_water_next = high_water_reg;
        alive_next      = alive_reg;
        rsp_next.status            = (act_reg == ACT_CREATE) ? ST_FULL : ST_STALE;
        rsp_next.entity_index      = '0;
        rsp_next.entity_generation = '0;
        rsp_next.live_count        = alive_reg;
        if (create_ok)
        begin
            slot_we    = ctl.commit;
            dlist_we   = ctl.commit;
            dpos_we    = ctl.commit;
            alive_next = alive_reg + 1'b1;
            if (use_free_reg)
            begin
                free_depth_next = fd_top;
            end
            else
            begin
                high_water_next = high_water_reg + 1'b1;
            end
            rsp_next.status            = ST_DONE;
            rsp_next.entity_index      = slot_idx_reg;
            rsp_next.entity_generation = create_gen;
            rsp_next.live_count        = alive_next;
        end
        else if (destroy_ok)
        begin
            // swap-remove: last dense entry moves into the freed position
            slot_we         = ctl.commit;
            slot_waddr      = hidx_reg;
            slot_wdata      = '{active: 1'b0, gen: gen_inc};
            dlist_we        = ctl.commit;
            dlist_waddr     = dpos_rd_reg;
            dlist_wdata     = dlist_rd_reg;
            dpos_we         = ctl.commit;
            dpos_waddr      = dlist_rd_reg;
            dpos_wdata      = dpos_rd_reg;
            fs_we           = ctl.commit;
            free_depth_next = free_depth_reg + 1'b1;
            alive_next      = last_pos;
            rsp_next.status            = ST_DONE;
            rsp_next.entity_index      = hidx_reg;
            rsp_next.entity_generation = gen_inc;
            rsp_next.live_count        = last_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dlist_we)
        begin
            dense_list[dlist_waddr] <= dlist_wdata;
        end
        if (ctl.start)
        begin
            dlist_rd_reg <= dense_list[last_pos[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dpos_we)
        begin
            dense_pos[dpos_waddr] <= dpos_wdata;
        end
        if (ctl.start)
        begin
            dpos_rd_reg <= dense_pos[req.handle_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            free_stack[free_depth_reg[IDX_W-1:0]] <= hidx_reg;
        end
        if (ctl.start)
        begin
            fs_rd_reg <= free_stack[fd_top[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            act_reg      <= req.action;
            hidx_reg     <= req.handle_index;
            hgen_reg     <= req.handle_generation;
            use_free_reg <= !free_empty;
            full_reg     <= free_empty && hw_full;
            unused_reg   <= idx_unused;
        end
        if (ctl.fetch)
        begin
            slot_idx_reg <= new_idx;
            fresh_reg    <= !use_free_reg;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            high_water_reg <= '0;
            alive_reg      <= '0;
        end
        else if (ctl.commit)
        begin
            free_depth_reg <= free_depth_next;
            high_water_reg <= high_water_next;
            alive_reg      <= alive_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_WORDS = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 38;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp;

    // allocator state mirror
    logic                slot_live      [CAPACITY];
    logic [GEN_BITS-1:0] slot_gen       [CAPACITY];
    logic [IDX_W-1:0]    dense_slots    [CAPACITY];
    logic [IDX_W-1:0]    dense_slot_pos [CAPACITY];
    logic [IDX_W-1:0]    free_slots     [CAPACITY];
    int                  free_count;
    int                  fresh_mark;
    int                  live_total;

    rsp_word_t expected_rsp [$];
    rsp_word_t oldest_rsp;

    int failures        = 0;
    int cycle_count     = 0;
    int done_count      = 0;
    int full_count      = 0;
    int stale_count     = 0;
    bit quiet           = 1'b0;
    int holds_requested = 0;
    int holds_done      = 0;
    int hold_count      = 0;

    always #5 clk = ~clk;

    generational_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    function automatic rsp_word_t allocate_or_release(req_word_t w);
        rsp_word_t        r;
        int               e;
        int               pos;
        logic [IDX_W-1:0] tail;
        r = '0;
        r.status = ST_DONE;
        if (w.action == ACT_CREATE)
        begin
            if (free_count > 0)
            begin
                free_count--;
                e = free_slots[free_count];
            end
            else if (fresh_mark < CAPACITY)
            begin
                e = fresh_mark;
                fresh_mark++;
            end
            else
                e = -1;
            if (e < 0 || live_total >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                slot_live[e] = 1'b1;
                dense_slot_pos[e] = IDX_W'(live_total);
                dense_slots[live_total] = IDX_W'(e);
                live_total++;
                r.entity_index = IDX_W'(e);
                r.entity_generation = slot_gen[e];
            end
        end
        else
        begin
            e = w.handle_index;
            if (e >= fresh_mark || !slot_live[e] || slot_gen[e] != w.handle_generation
                || live_total == 0)
                r.status = ST_STALE;
            else
            begin
                // swap-remove from the dense list
                pos = dense_slot_pos[e];
                tail = dense_slots[live_total - 1];
                dense_slots[pos] = tail;
                dense_slot_pos[tail] = IDX_W'(pos);
                live_total--;
                slot_live[e] = 1'b0;
                slot_gen[e] = slot_gen[e] + 1'b1;
                if (free_count < CAPACITY)
                begin
                    free_slots[free_count] = IDX_W'(e);
                    free_count++;
                end
                r.entity_index = IDX_W'(e);
                r.entity_generation = slot_gen[e];
            end
        end
        r.live_count = CNT_W'(live_total);
        return r;
    endfunction

    function automatic req_word_t create_word();
        req_word_t w;
        w.action = ACT_CREATE;
        w.handle_index = IDX_W'($urandom);
        w.handle_generation = GEN_BITS'($urandom);
        return w;
    endfunction

    function automatic req_word_t destroy_word(int idx, logic [GEN_BITS-1:0] gen);
        req_word_t w;
        w.action = ACT_DESTROY;
        w.handle_index = IDX_W'(idx);
        w.handle_generation = gen;
        return w;
    endfunction

    function automatic req_word_t live_destroy_word();
        int idx;
        idx = dense_slots[$urandom_range(0, live_total - 1)];
        return destroy_word(idx, slot_gen[idx]);
    endfunction

    // stale or malformed handles
    function automatic req_word_t noise_word();
        int idx;
        idx = 0;
        case ($urandom_range(0, 3))
            1:
            begin
                if (live_total > 0)
                begin
                    idx = dense_slots[$urandom_range(0, live_total - 1)];
                    return destroy_word(idx,
                        slot_gen[idx] ^ GEN_BITS'($urandom_range(1, (1 << GEN_BITS) - 1)));
                end
            end
            2:
            begin
                if (fresh_mark < CAPACITY)
                    return destroy_word($urandom_range(fresh_mark, CAPACITY - 1),
                                        GEN_BITS'($urandom_range(0, 1)));
            end
            3:
            begin
                if (free_count > 0)
                begin
                    idx = free_slots[$urandom_range(0, free_count - 1)];
                    return destroy_word(idx, slot_gen[idx] - 1'b1);
                end
            end
            default:
            begin
            end
        endcase
        return destroy_word($urandom_range(0, CAPACITY - 1), GEN_BITS'($urandom));
    endfunction

    task automatic send_word(req_word_t w);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsp.insert(expected_rsp.size(), allocate_or_release(w));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(create_word());
        send_word(create_word());
        send_word(create_word());
        send_word('{action: ACT_CREATE, handle_index: '1, handle_generation: '1});
        // front of the dense list, then double destroy
        send_word(destroy_word(0, 0));
        send_word(destroy_word(0, 0));
        send_word(destroy_word(1, '1));
        send_word(destroy_word(CAPACITY - 1, '1));
        send_word(destroy_word(3, 0));
        // tail of the dense list
        send_word(destroy_word(1, 0));
        send_word(create_word());
        send_word(create_word());
        send_word(create_word());
        send_word(create_word());
        send_word(destroy_word(2, 0));
        send_word(destroy_word(4, 0));
        send_word(destroy_word(0, 0));
        send_word(destroy_word(0, 1));
        send_word(destroy_word(1, 1));
        send_word(destroy_word(3, 1));
        send_word(destroy_word(5, 0));
        wait_drained();
    endtask

    task automatic test_random_mix();
        int create_pct;
        int r;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            create_pct = (n < 40) ? 60 : (n < 70) ? 45 : 30;
            quiet = (n >= 20 && n < 60);
            if (n == 70)
                holds_requested++;
            r = $urandom_range(0, 99);
            if (r < create_pct)
                send_word(create_word());
            else if (r < 88 && live_total > 0)
                send_word(live_destroy_word());
            else
                send_word(noise_word());
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_fill_to_full();
        while (fresh_mark < CAPACITY || free_count > 0)
            send_word(create_word());
        repeat (3) send_word(create_word());
        repeat (5) send_word(live_destroy_word());
        repeat (6) send_word(create_word());
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            rsp_ready <= 1'b0;
        end
        else if (holds_done != holds_requested)
        begin
            holds_done <= holds_done + 1;
            hold_count <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("rsp word with nothing expected: status %0d index %0d",
                       rsp.status, rsp.entity_index);
                failures++;
            end
            else
            begin
                oldest_rsp = expected_rsp.pop_front();
                case (oldest_rsp.status)
                    ST_DONE: done_count++;
                    ST_FULL: full_count++;
                    default: stale_count++;
                endcase
                if (rsp.status !== oldest_rsp.status)
                begin
                    $error("status expected %0d actual %0d", oldest_rsp.status, rsp.status);
                    failures++;
                end
                if (rsp.entity_index !== oldest_rsp.entity_index)
                begin
                    $error("entity_index expected %0d actual %0d",
                           oldest_rsp.entity_index, rsp.entity_index);
                    failures++;
                end
                if (rsp.entity_generation !== oldest_rsp.entity_generation)
                begin
                    $error("entity_generation expected %0d actual %0d",
                           oldest_rsp.entity_generation, rsp.entity_generation);
                    failures++;
                end
                if (rsp.live_count !== oldest_rsp.live_count)
                begin
                    $error("live_count expected %0d actual %0d",
                           oldest_rsp.live_count, rsp.live_count);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL generational_slot_allocator");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_live[i] = 1'b0;
            slot_gen[i] = '0;
        end
        free_count = 0;
        fresh_mark = 0;
        live_total = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_to_full();
        test_random_mix();
        $display("checked %0d rsp words: %0d done, %0d refused as full, %0d stale handles",
                 done_count + full_count + stale_count, done_count, full_count, stale_count);
        $display("store filled to capacity with refused creates and free stack reuse, "
                 , "then mixed traffic near full");
        if (failures == 0)
            $display("PASS generational_slot_allocator");
        else
            $display("FAIL generational_slot_allocator");
        $finish;
    end

endmodule

`default_nettype wire
